[rtl/clcd_pkg.sv]
// Package for the character LCD sequencer: request codes, queue entry type,
// delay constants and the init command table. No dependencies.
`default_nettype none
package clcd_pkg;

  typedef enum logic [2:0] {
    CMD_INIT      = 3'd0,
    CMD_BYTE      = 3'd1,
    CMD_DATA      = 3'd2,
    CMD_CURSOR    = 3'd3,
    CMD_CLEAR     = 3'd4,
    CMD_STR_START = 3'd5,
    CMD_STR_CHAR  = 3'd6
  } cmd_e;

  typedef enum logic {
    CFG_DELAY_SHIFT    = 1'b0,
    CFG_CHARS_PER_LINE = 1'b1
  } cfg_idx_e;

  typedef enum logic {
    F_IDLE,
    F_ISSUE
  } front_state_e;

  typedef enum logic [1:0] {
    B_IDLE,
    B_LEAD,
    B_NIB
  } back_state_e;

  // One queue entry: a byte with its lead wait, or the init nibble prelude
  typedef struct packed {
    logic       init_head;
    logic       rs;
    logic [7:0] val;
    logic       last;
  } job_t;

  localparam int QUEUE_DEPTH = 4;
  localparam int UNITS_W     = 13;
  localparam int WAIT_W      = 25;
  localparam int SHIFT_W     = 4;
  localparam int CPL_W       = 6;
  localparam int COUNT_W     = 6;
  localparam int JOBS_W      = 3;

  localparam logic [3:0]         MAX_SHIFT  = 4'd12;
  localparam logic [COUNT_W-1:0] COUNT_MAX  = 6'd63;
  localparam logic [7:0]         DDRAM_SET  = 8'h80;
  localparam logic [7:0]         CLEAR_BYTE = 8'h01;
  localparam logic [3:0]         NIB_WAKE   = 4'h3;
  localparam logic [3:0]         NIB_4BIT   = 4'h2;

  localparam logic [UNITS_W-1:0] CMD_LEAD   = 13'd1500;
  localparam logic [UNITS_W-1:0] DATA_LEAD  = 13'd200;
  localparam logic [UNITS_W-1:0] NIB_UNITS  = 13'd2;
  localparam logic [UNITS_W-1:0] WAKE_TAIL0 = 13'd4100;
  localparam logic [UNITS_W-1:0] WAKE_TAIL1 = 13'd100;

  localparam logic [JOBS_W-1:0]  INIT_JOBS  = 3'd6;

  function automatic logic [7:0] init_byte(input logic [JOBS_W-1:0] idx);
    logic [7:0] b;
    case (idx)
      3'd1:    b = 8'h28;
      3'd2:    b = 8'h0C;
      3'd3:    b = 8'h06;
      3'd4:    b = 8'h40;
      default: b = 8'h80;
    endcase
    return b;
  endfunction

endpackage
`default_nettype wire

[rtl/clcd_req_if.sv]
// Request channel: valid/ready handshake with the request fields.
// Depends on nothing.
`default_nettype none
interface clcd_req_if;
  logic       valid;
  logic       ready;
  logic [2:0] cmd;
  logic [7:0] byte_value;
  logic [6:0] column;
  logic [1:0] line;

  modport source (output valid, cmd, byte_value, column, line, input ready);
  modport sink (input valid, cmd, byte_value, column, line, output ready);
endinterface
`default_nettype wire

[rtl/clcd_step_if.sv]
// Pin step channel: valid/ready handshake with one timed pin state.
// Depends on nothing.
`default_nettype none
interface clcd_step_if;
  logic        valid;
  logic        ready;
  logic        reg_select;
  logic        enable;
  logic [3:0]  nibble;
  logic [24:0] wait_cycles;
  logic        last;

  modport source (output valid, reg_select, enable, nibble, wait_cycles, last,
                  input ready);
  modport sink (input valid, reg_select, enable, nibble, wait_cycles, last,
                output ready);
endinterface
`default_nettype wire

[rtl/clcd_front.sv]
// Front end: accepts requests, keeps the string character count and issues
// byte jobs into the queue. Depends on clcd_pkg and clcd_req_if.
`default_nettype none
module clcd_front
  import clcd_pkg::*;
#(
  parameter int LINE_STRIDE = 40
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  clcd_req_if.sink              req_i,
  input  wire logic [CPL_W-1:0] chars_per_line_i,
  output job_t                  job_o,
  output logic                  push_o,
  input  wire logic             full_i
);

  front_state_e        state_q, state_d;
  logic [COUNT_W-1:0]  count_q, count_d;
  cmd_e                cmd_q;
  logic [7:0]          val_q;
  logic [6:0]          addr_q;
  logic                wrap_q;
  logic [JOBS_W-1:0]   njobs_q, idx_q, idx_d;
  logic [JOBS_W-1:0]   njobs;
  logic [6:0]          addr;
  logic                wrap;
  logic                accept;
  logic                last_push;
  logic [COUNT_W-1:0]  count_inc;

  assign req_i.ready = (state_q == F_IDLE);
  assign accept      = req_i.valid && req_i.ready;
  assign count_inc   = count_q + COUNT_W'(1);

  always_comb begin
    njobs   = '0;
    wrap    = 1'b0;
    count_d = count_q;
    addr    = 7'(int'(req_i.line) * LINE_STRIDE) + req_i.column;
    case (req_i.cmd)
      CMD_INIT: begin
        njobs = INIT_JOBS;
      end
      CMD_BYTE, CMD_DATA, CMD_CURSOR: begin
        njobs = JOBS_W'(1);
      end
      CMD_CLEAR: begin
        njobs = JOBS_W'(2);
        addr  = '0;
      end
      CMD_STR_START: begin
        njobs   = JOBS_W'(1);
        addr    = '0;
        count_d = '0;
      end
      CMD_STR_CHAR: begin
        addr = 7'(LINE_STRIDE);
        if (req_i.byte_value != 8'h00) begin
          if (count_q != COUNT_MAX) begin
            count_d = count_inc;
            wrap    = (count_inc == chars_per_line_i);
          end
          njobs = wrap ? JOBS_W'(2) : JOBS_W'(1);
        end
      end
      default: begin
        njobs = '0;
      end
    endcase
    if (!accept) begin
      count_d = count_q;
    end
  end

  assign last_push = push_o && (idx_q == njobs_q - JOBS_W'(1));

  always_comb begin
    state_d = state_q;
    idx_d   = idx_q;
    case (state_q)
      F_IDLE: begin
        idx_d = '0;
        if (accept && njobs != '0) begin
          state_d = F_ISSUE;
        end
      end
      F_ISSUE: begin
        if (push_o) begin
          idx_d = idx_q + JOBS_W'(1);
        end
        if (last_push) begin
          state_d = F_IDLE;
        end
      end
      default: begin
        state_d = F_IDLE;
      end
    endcase
  end

  always_comb begin
    push_o = (state_q == F_ISSUE) && !full_i;
    job_o  = '{init_head: 1'b0, rs: 1'b0, val: DDRAM_SET | {1'b0, addr_q}, last: 1'b1};
    case (cmd_q)
      CMD_INIT: begin
        job_o.init_head = (idx_q == '0);
        job_o.val       = init_byte(idx_q);
        job_o.last      = (idx_q == INIT_JOBS - JOBS_W'(1));
      end
      CMD_BYTE: begin
        job_o.val = val_q;
      end
      CMD_DATA: begin
        job_o.rs  = 1'b1;
        job_o.val = val_q;
      end
      CMD_CLEAR: begin
        if (idx_q == '0) begin
          job_o.val  = CLEAR_BYTE;
          job_o.last = 1'b0;
        end
      end
      CMD_STR_CHAR: begin
        if (idx_q == '0) begin
          job_o.rs   = 1'b1;
          job_o.val  = val_q;
          job_o.last = !wrap_q;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= F_IDLE;
      count_q <= '0;
      idx_q   <= '0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      idx_q   <= idx_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      cmd_q   <= cmd_e'(req_i.cmd);
      val_q   <= req_i.byte_value;
      addr_q  <= addr;
      wrap_q  <= wrap;
      njobs_q <= njobs;
    end
  end

endmodule
`default_nettype wire

[rtl/clcd_fifo.sv]
// Short job queue between front and back end.
// Depends on clcd_pkg.
`default_nettype none
module clcd_fifo
  import clcd_pkg::*;
(
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  job_t      wr_job_i,
  input  wire logic push_i,
  output logic      full_o,
  output job_t      rd_job_o,
  input  wire logic pop_i,
  output logic      empty_o
);

  localparam int PTR_W = $clog2(QUEUE_DEPTH);

  job_t             mem_q [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [PTR_W:0]   fill_q;

  assign full_o   = (fill_q == (PTR_W+1)'(QUEUE_DEPTH));
  assign empty_o  = (fill_q == '0);
  assign rd_job_o = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= wr_job_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      fill_q   <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= wr_ptr_q + PTR_W'(1);
      end
      if (pop_i) begin
        rd_ptr_q <= rd_ptr_q + PTR_W'(1);
      end
      fill_q <= fill_q + (PTR_W+1)'(push_i) - (PTR_W+1)'(pop_i);
    end
  end

endmodule
`default_nettype wire

[rtl/clcd_back.sv]
// Back end: expands queued jobs into timed pin steps behind an output register.
// Depends on clcd_pkg and clcd_step_if.
`default_nettype none
module clcd_back
  import clcd_pkg::*;
(
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  job_t                    job_i,
  input  wire logic               empty_i,
  output logic                    pop_o,
  input  wire logic [SHIFT_W-1:0] delay_shift_i,
  clcd_step_if.source             step_o
);

  back_state_e         state_q, state_d;
  job_t                job_q;
  logic [2:0]          nstep_q, nstep_d;
  logic                rs_lvl_q, nib_lvl_d;
  logic [3:0]          nib_lvl_q;
  logic                o_valid_q;
  logic                o_rs_q, o_en_q, o_last_q;
  logic [3:0]          o_nib_q;
  logic [WAIT_W-1:0]   o_wait_q;
  logic                adv, emit, final_step;
  logic [2:0]          final_idx;
  logic [1:0]          nib_idx;
  logic                e_rs, e_en, e_last;
  logic [3:0]          e_nib;
  logic [UNITS_W-1:0]  e_units, tail;
  logic [3:0]          sh;

  assign adv        = !o_valid_q || step_o.ready;
  assign final_idx  = job_q.init_head ? 3'd7 : 3'd3;
  assign final_step = (nstep_q == final_idx);
  assign nib_idx    = nstep_q[2:1];
  assign sh         = (delay_shift_i > MAX_SHIFT) ? MAX_SHIFT : delay_shift_i;
  assign nib_lvl_d  = 1'b0;

  always_comb begin
    state_d = state_q;
    nstep_d = nstep_q;
    case (state_q)
      B_IDLE: begin
        if (!empty_i) begin
          state_d = B_LEAD;
        end
      end
      B_LEAD: begin
        nstep_d = '0;
        if (adv) begin
          state_d = B_NIB;
        end
      end
      B_NIB: begin
        if (adv) begin
          nstep_d = nstep_q + 3'd1;
          if (final_step) begin
            state_d = B_IDLE;
          end
        end
      end
      default: begin
        state_d = B_IDLE;
      end
    endcase
  end

  always_comb begin
    pop_o  = (state_q == B_IDLE) && !empty_i;
    emit   = 1'b0;
    e_rs   = rs_lvl_q;
    e_en   = 1'b0;
    e_nib  = nib_lvl_q;
    e_last = 1'b0;
    tail   = '0;
    if (job_q.init_head) begin
      if (nib_idx == 2'd0) begin
        tail = WAKE_TAIL0;
      end else if (nib_idx == 2'd1) begin
        tail = WAKE_TAIL1;
      end
    end
    e_units = NIB_UNITS;
    case (state_q)
      B_LEAD: begin
        emit    = adv;
        e_rs    = job_q.rs;
        e_units = job_q.rs ? DATA_LEAD : CMD_LEAD;
      end
      B_NIB: begin
        emit   = adv;
        e_en   = !nstep_q[0];
        e_last = job_q.last && final_step;
        if (job_q.init_head) begin
          e_nib = (nib_idx == 2'd3) ? NIB_4BIT : NIB_WAKE;
        end else begin
          e_nib = (nib_idx == 2'd0) ? job_q.val[7:4] : job_q.val[3:0];
        end
        if (nstep_q[0]) begin
          e_units = NIB_UNITS + tail;
        end
      end
      default: begin
      end
    endcase
  end

  assign step_o.valid       = o_valid_q;
  assign step_o.reg_select  = o_rs_q;
  assign step_o.enable      = o_en_q;
  assign step_o.nibble      = o_nib_q;
  assign step_o.wait_cycles = o_wait_q;
  assign step_o.last        = o_last_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= B_IDLE;
      nstep_q   <= '0;
      rs_lvl_q  <= 1'b0;
      nib_lvl_q <= {3'b000, nib_lvl_d};
      o_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      nstep_q <= nstep_d;
      if (emit) begin
        rs_lvl_q  <= e_rs;
        nib_lvl_q <= e_nib;
        o_valid_q <= 1'b1;
      end else if (step_o.ready) begin
        o_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      job_q <= job_i;
    end
    if (emit) begin
      o_rs_q   <= e_rs;
      o_en_q   <= e_en;
      o_nib_q  <= e_nib;
      o_last_q <= e_last;
      o_wait_q <= WAIT_W'(e_units) << sh;
    end
  end

endmodule
`default_nettype wire

[rtl/char_lcd_4bit_sequencer.sv]
// Character LCD sequencer for an HD44780-style controller on a 4-bit bus.
// Requests enter on req_i (valid/ready); each is turned into timed pin steps
// on step_o (valid/ready), one step per transfer, the final step of a request
// flagged by last. A step holds RS, E and the data nibble; its wait_cycles
// field is (delay units << delay_shift), shift capped at 12. The front end
// registers a request and queues one byte job per cycle while the queue is
// not full (six for init); the back end fetches a job in its idle state and
// then emits one step per cycle while the receiver takes them. A byte is a
// lead wait step plus four nibble steps. The first step passes the request
// registers, the queue and the job register before the output register.
// A stalled receiver holds the output register; the queue fills, and
// req_i.ready, low while a request is queued, stays low until the current
// request has been fully queued. Reset clears the string character count and
// pin levels and loads delay_shift 4 and chars_per_line 16. Write
// configuration through cfg_we_i/cfg_idx_i/cfg_data_i only while idle.
// Depends on clcd_pkg, clcd_req_if, clcd_step_if, clcd_front, clcd_fifo and
// clcd_back.
`default_nettype none
module char_lcd_4bit_sequencer
  import clcd_pkg::*;
#(
  parameter int LINE_STRIDE = 40
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  clcd_req_if.sink              req_i,
  clcd_step_if.source           step_o,
  input  wire logic             cfg_we_i,
  input  wire logic             cfg_idx_i,
  input  wire logic [CPL_W-1:0] cfg_data_i
);

  logic [SHIFT_W-1:0] delay_shift_q;
  logic [CPL_W-1:0]   chars_per_line_q;
  job_t               fjob, bjob;
  logic               push, full, pop, empty;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      delay_shift_q    <= SHIFT_W'(4);
      chars_per_line_q <= CPL_W'(16);
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CFG_DELAY_SHIFT:    delay_shift_q    <= cfg_data_i[SHIFT_W-1:0];
        CFG_CHARS_PER_LINE: chars_per_line_q <= cfg_data_i;
        default: begin
        end
      endcase
    end
  end

  clcd_front #(
    .LINE_STRIDE(LINE_STRIDE)
  ) u_front (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .req_i           (req_i),
    .chars_per_line_i(chars_per_line_q),
    .job_o           (fjob),
    .push_o          (push),
    .full_i          (full)
  );

  clcd_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .wr_job_i(fjob),
    .push_i  (push),
    .full_o  (full),
    .rd_job_o(bjob),
    .pop_i   (pop),
    .empty_o (empty)
  );

  clcd_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .job_i        (bjob),
    .empty_i      (empty),
    .pop_o        (pop),
    .delay_shift_i(delay_shift_q),
    .step_o       (step_o)
  );

endmodule
`default_nettype wire

[tb/clcd_step_checker.sv]
`timescale 1ns / 1ps
// Pin step checker for char_lcd_4bit_sequencer: mirrors the configuration writes, predicts
// the timed pin steps of each request transfer and compares every step transfer in order.
// Depends on clcd_pkg, clcd_req_if and clcd_step_if.
module clcd_step_checker
  import clcd_pkg::*;
#(
  parameter int LINE_STRIDE = 40
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  clcd_req_if              req,
  clcd_step_if             step,
  input  logic             cfg_we_i,
  input  logic             cfg_idx_i,
  input  logic [CPL_W-1:0] cfg_data_i,
  output int               pending_o,
  output int               mismatch_o
);

  localparam int unsigned CMD_LEAD_UNITS  = 1500;
  localparam int unsigned DATA_LEAD_UNITS = 200;
  localparam int unsigned STROBE_UNITS    = 2;
  localparam int unsigned WAKE_TAIL_LONG  = 4100;
  localparam int unsigned WAKE_TAIL_SHORT = 100;
  localparam logic [3:0]  SHIFT_CAP       = 4'd12;
  localparam logic [5:0]  CHAR_COUNT_MAX  = 6'd63;

  typedef struct packed {
    logic        rs;
    logic        en;
    logic [3:0]  nib;
    logic [24:0] wait_cyc;
    logic        last;
  } pin_step_t;

  pin_step_t  pin_steps_q[$];
  logic [5:0] str_count;
  logic       rs_lvl;
  logic [3:0] nib_lvl;
  logic [3:0] shift_q;
  logic [5:0] cpl_q;
  int         mismatches;
  pin_step_t  seen;
  pin_step_t  want;

  function automatic void add_pin_step(logic rs, logic en, logic [3:0] nib,
                                       int unsigned units);
    pin_step_t  s;
    logic [3:0] sh;
    sh = (shift_q > SHIFT_CAP) ? SHIFT_CAP : shift_q;
    s.rs       = rs;
    s.en       = en;
    s.nib      = nib;
    s.wait_cyc = 25'(units) << sh;
    s.last     = 1'b0;
    pin_steps_q.push_back(s);
    rs_lvl  = rs;
    nib_lvl = nib;
  endfunction

  function automatic void add_nibble_strobe(logic [3:0] v, int unsigned tail);
    add_pin_step(rs_lvl, 1'b1, v, STROBE_UNITS);
    add_pin_step(rs_lvl, 1'b0, v, STROBE_UNITS + tail);
  endfunction

  function automatic void add_byte_steps(logic rs, logic [7:0] b);
    add_pin_step(rs, 1'b0, nib_lvl, rs ? DATA_LEAD_UNITS : CMD_LEAD_UNITS);
    add_nibble_strobe(b[7:4], 0);
    add_nibble_strobe(b[3:0], 0);
  endfunction

  function automatic void add_cursor_move(logic [6:0] col, logic [1:0] ln);
    logic [6:0] addr;
    addr = 7'(int'(ln) * LINE_STRIDE + int'(col));
    add_byte_steps(1'b0, {1'b1, addr});
  endfunction

  function automatic void predict_pin_steps(logic [2:0] cmd, logic [7:0] bv,
                                            logic [6:0] col, logic [1:0] ln);
    int unsigned first_idx;
    pin_step_t   t;
    first_idx = pin_steps_q.size();
    case (cmd)
      CMD_INIT: begin
        add_pin_step(1'b0, 1'b0, nib_lvl, CMD_LEAD_UNITS);
        add_nibble_strobe(4'h3, WAKE_TAIL_LONG);
        add_nibble_strobe(4'h3, WAKE_TAIL_SHORT);
        add_nibble_strobe(4'h3, 0);
        add_nibble_strobe(4'h2, 0);
        add_byte_steps(1'b0, 8'h28);
        add_byte_steps(1'b0, 8'h0C);
        add_byte_steps(1'b0, 8'h06);
        add_byte_steps(1'b0, 8'h40);
        add_byte_steps(1'b0, 8'h80);
      end
      CMD_BYTE:   add_byte_steps(1'b0, bv);
      CMD_DATA:   add_byte_steps(1'b1, bv);
      CMD_CURSOR: add_cursor_move(col, ln);
      CMD_CLEAR: begin
        add_byte_steps(1'b0, 8'h01);
        add_cursor_move(7'd0, 2'd0);
      end
      CMD_STR_START: begin
        str_count = '0;
        add_cursor_move(7'd0, 2'd0);
      end
      CMD_STR_CHAR: begin
        if (bv != 8'h00) begin
          add_byte_steps(1'b1, bv);
          if (str_count < CHAR_COUNT_MAX) begin
            str_count = str_count + 6'd1;
            if (str_count == cpl_q) add_cursor_move(7'd0, 2'd1);
          end
        end
      end
      default: ;
    endcase
    if (pin_steps_q.size() > first_idx) begin
      t = pin_steps_q[pin_steps_q.size() - 1];
      t.last = 1'b1;
      pin_steps_q[pin_steps_q.size() - 1] = t;
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pin_steps_q.delete();
      str_count  = '0;
      rs_lvl     = 1'b0;
      nib_lvl    = 4'h0;
      shift_q    = 4'd4;
      cpl_q      = 6'd16;
      mismatches = 0;
      pending_o  <= 0;
      mismatch_o <= 0;
    end else begin
      if (step.valid && step.ready) begin
        seen = '{step.reg_select, step.enable, step.nibble, step.wait_cycles, step.last};
        if (pin_steps_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: unexpected step rs=%0d e=%0d nib=%h wait=%0d last=%0d",
                     seen.rs, seen.en, seen.nib, seen.wait_cyc, seen.last);
        end else begin
          want = pin_steps_q.pop_front();
          if (want != seen) begin
            mismatches++;
            if (mismatches <= 10)
              $display("mismatch: expected rs=%0d e=%0d nib=%h wait=%0d last=%0d, %s",
                       want.rs, want.en, want.nib, want.wait_cyc, want.last,
                       $sformatf("got rs=%0d e=%0d nib=%h wait=%0d last=%0d",
                                 seen.rs, seen.en, seen.nib, seen.wait_cyc, seen.last));
          end
        end
      end
      if (req.valid && req.ready)
        predict_pin_steps(req.cmd, req.byte_value, req.column, req.line);
      if (cfg_we_i) begin
        case (cfg_idx_e'(cfg_idx_i))
          CFG_DELAY_SHIFT:    shift_q = cfg_data_i[3:0];
          CFG_CHARS_PER_LINE: cpl_q = cfg_data_i;
          default: ;
        endcase
      end
      pending_o  <= pin_steps_q.size();
      mismatch_o <= mismatches;
    end
  end

endmodule

[tb/tb_top.sv]
`timescale 1ns / 1ps
// Top of the char_lcd_4bit_sequencer testbench: clock, reset, request and configuration
// stimulus, random output stalls and the verdict. Depends on clcd_pkg, both channel
// interfaces, the sequencer and clcd_step_checker.
module tb_top;
  import clcd_pkg::*;

  localparam int          STRIDE      = 40;
  localparam int unsigned STALL_LIMIT = 3000;
  localparam int          SETTLE      = 16;
  localparam int          DRAIN       = 64;
  localparam logic [2:0]  CMD_UNUSED  = 3'd7;

  logic             clk;
  logic             rst_n;
  logic             cfg_we;
  logic             cfg_idx;
  logic [CPL_W-1:0] cfg_data;
  int               pending;
  int               mismatches;
  int unsigned      quiet_cycles;
  bit               no_idle;

  clcd_req_if  req_ch ();
  clcd_step_if step_ch ();

  char_lcd_4bit_sequencer #(.LINE_STRIDE(STRIDE)) dut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .req_i      (req_ch),
    .step_o     (step_ch),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data)
  );

  clcd_step_checker #(.LINE_STRIDE(STRIDE)) u_checker (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .req        (req_ch),
    .step       (step_ch),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data),
    .pending_o  (pending),
    .mismatch_o (mismatches)
  );

  initial clk = 1'b0;
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (!rst_n || (req_ch.valid && req_ch.ready) || (step_ch.valid && step_ch.ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles == STALL_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  initial begin
    step_ch.ready = 1'b0;
    wait (rst_n);
    @(posedge clk);
    forever begin
      if (!no_idle && $urandom_range(0, 4) == 0) begin
        step_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 9)) @(posedge clk);
      end
      step_ch.ready <= 1'b1;
      repeat ($urandom_range(1, 16)) @(posedge clk);
    end
  end

  task automatic send_req(input logic [2:0] cmd, input logic [7:0] bv,
                          input logic [6:0] col, input logic [1:0] ln);
    if (!no_idle && $urandom_range(0, 3) == 0) begin
      req_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 9)) @(posedge clk);
    end
    req_ch.valid      <= 1'b1;
    req_ch.cmd        <= cmd;
    req_ch.byte_value <= bv;
    req_ch.column     <= col;
    req_ch.line       <= ln;
    @(posedge clk);
    while (!req_ch.ready) @(posedge clk);
  endtask

  // Drop valid, wait for every predicted step, then let the front end settle
  task automatic settle();
    req_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_config(input logic [CPL_W-1:0] shift_word,
                              input logic [CPL_W-1:0] cpl_word);
    cfg_we   <= 1'b1;
    cfg_idx  <= CFG_DELAY_SHIFT;
    cfg_data <= shift_word;
    @(posedge clk);
    cfg_idx  <= CFG_CHARS_PER_LINE;
    cfg_data <= cpl_word;
    @(posedge clk);
    cfg_we   <= 1'b0;
  endtask

  task automatic run_mix(input int n_items);
    int         sent;
    int         k;
    logic [7:0] ch;
    sent = 0;
    while (sent < n_items) begin
      case ($urandom_range(0, 11))
        0, 1, 2, 3, 4: begin
          if ($urandom_range(0, 3) != 0) begin
            send_req(CMD_STR_START, 8'($urandom), 7'($urandom), 2'($urandom));
            sent++;
          end
          k = $urandom_range(1, 20);
          repeat (k) begin
            ch = ($urandom_range(0, 9) == 0) ? 8'h00 : 8'($urandom_range(1, 255));
            send_req(CMD_STR_CHAR, ch, 7'($urandom), 2'($urandom));
            if (ch != 8'h00) sent++;
          end
        end
        5: begin
          send_req(CMD_INIT, 8'($urandom), 7'($urandom), 2'($urandom));
          sent++;
        end
        6: begin
          send_req(CMD_BYTE, 8'($urandom), 7'($urandom), 2'($urandom));
          sent++;
        end
        7: begin
          send_req(CMD_DATA, 8'($urandom), 7'($urandom), 2'($urandom));
          sent++;
        end
        8, 9: begin
          send_req(CMD_CURSOR, 8'($urandom), 7'($urandom), 2'($urandom));
          sent++;
        end
        10: begin
          send_req(CMD_CLEAR, 8'($urandom), 7'($urandom), 2'($urandom));
          sent++;
        end
        default: send_req(CMD_UNUSED, 8'($urandom), 7'($urandom), 2'($urandom));
      endcase
    end
  endtask

  initial begin
    rst_n             = 1'b0;
    no_idle           = 1'b0;
    cfg_we            = 1'b0;
    cfg_idx           = CFG_DELAY_SHIFT;
    cfg_data          = '0;
    req_ch.valid      = 1'b0;
    req_ch.cmd        = CMD_INIT;
    req_ch.byte_value = 8'h00;
    req_ch.column     = 7'd0;
    req_ch.line       = 2'd0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset configuration: shift 4, 16 characters per line
    send_req(CMD_INIT, 8'h00, 7'd0, 2'd0);
    send_req(CMD_BYTE, 8'h00, 7'd0, 2'd0);
    send_req(CMD_BYTE, 8'hFF, 7'd127, 2'd3);
    send_req(CMD_DATA, 8'h00, 7'd0, 2'd0);
    send_req(CMD_DATA, 8'hFF, 7'd127, 2'd3);
    send_req(CMD_CURSOR, 8'h00, 7'd0, 2'd0);
    send_req(CMD_CURSOR, 8'hFF, 7'd127, 2'd3);
    send_req(CMD_CURSOR, 8'h00, 7'd90, 2'd2);
    send_req(CMD_CURSOR, 8'h00, 7'd39, 2'd1);
    send_req(CMD_CLEAR, 8'h5A, 7'd64, 2'd1);
    send_req(CMD_UNUSED, 8'hA5, 7'd33, 2'd2);
    send_req(CMD_STR_CHAR, 8'h41, 7'd0, 2'd0);
    send_req(CMD_STR_START, 8'h00, 7'd0, 2'd0);
    send_req(CMD_STR_CHAR, 8'h00, 7'd0, 2'd0);
    send_req(CMD_STR_CHAR, 8'h7E, 7'd0, 2'd0);
    send_req(CMD_STR_CHAR, 8'hFF, 7'd0, 2'd0);
    send_req(CMD_INIT, 8'hFF, 7'd127, 2'd3);
    settle();

    write_config(6'd0, 6'd1);
    run_mix(20);
    settle();

    write_config(6'h3F, 6'd40);
    run_mix(20);
    settle();

    write_config(6'd12, 6'd0);
    run_mix(20);
    settle();

    // Long string: wrap on the 63rd character, then hold the count
    write_config(6'd3, 6'd63);
    send_req(CMD_STR_START, 8'h00, 7'd0, 2'd0);
    repeat (66) send_req(CMD_STR_CHAR, 8'($urandom_range(1, 255)), 7'($urandom),
                         2'($urandom));
    settle();

    no_idle = 1'b1;
    write_config(6'($urandom), 6'($urandom_range(1, 63)));
    run_mix(25);
    settle();

    repeat (DRAIN) @(posedge clk);
    if (mismatches == 0 && pending == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

[sim.f]
rtl/clcd_pkg.sv
rtl/clcd_req_if.sv
rtl/clcd_step_if.sv
rtl/clcd_front.sv
rtl/clcd_fifo.sv
rtl/clcd_back.sv
rtl/char_lcd_4bit_sequencer.sv
tb/clcd_step_checker.sv
tb/tb_top.sv
